// ===== src/pii_pkg.sv =====
// Shared types, codes and word encoding for the pending interrupt injector.
package pii_pkg;

	localparam int PENDING_WORDS_DEF = 4;
	localparam int WORD_BITS = 64;

	localparam logic [2:0] OP_INJECT_EVENT = 3'd0;
	localparam logic [2:0] OP_EXT_INTR     = 3'd1;
	localparam logic [2:0] OP_NMI          = 3'd2;
	localparam logic [2:0] OP_EXCEPTION    = 3'd3;
	localparam logic [2:0] OP_DRAIN        = 3'd4;

	localparam logic [2:0] TYPE_INTR      = 3'd0;
	localparam logic [2:0] TYPE_NMI       = 3'd2;
	localparam logic [2:0] TYPE_EXCEPTION = 3'd3;

	localparam logic [7:0] NMI_VEC_NUM = 8'd2;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  vector;
		logic [2:0]  event_type;
		logic [31:0] err_code;
		logic        code_valid;
	} req_t;

	typedef struct packed {
		logic [63:0] injection_word;
		logic        word_written;
		logic        drain_found;
		logic [7:0]  drained_vector;
	} rsp_t;

	typedef struct packed {
		logic       found;
		logic [5:0] idx;
	} msb_t;

	// vector 7:0, type 10:8, error-code valid 11, valid 31, error code 63:32
	function automatic logic [63:0] make_word(input logic [7:0] vec, input logic [2:0] typ,
		input logic [31:0] ec, input logic ecv);
		logic [63:0] w;
		w = '0;
		w[7:0] = vec;
		w[10:8] = typ;
		w[31] = 1'b1;
		if (ecv) begin
			w[11] = 1'b1;
			w[63:32] = ec;
		end
		return w;
	endfunction

endpackage

// ===== src/pii_msb_find.sv =====
// Highest set bit search over one 64-bit pending word.
module pii_msb_find (
	input  logic [63:0]   bits,
	output pii_pkg::msb_t msb
);
	import pii_pkg::*;

	always_comb begin
		msb = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (bits[i]) begin
				msb.found = 1'b1;
				msb.idx = 6'(i);
			end
		end
	end

endmodule

// ===== src/pending_interrupt_injector_top.sv =====
// Pending interrupt injector: 256-bit pending register with injection word encoding.
//
// Request channel: req is taken at a rising edge where start is high and busy
// is low. Opcodes inject an event, an external interrupt, an NMI or an
// exception, or drain the highest pending vector.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall, so results are never held.
// The request edge moves the block into EXEC, and done and rsp are registered at the
// end of EXEC; busy is high in EXEC, so no new request is taken until then.
// The pending bits live in a one-read-port synchronous memory of PENDING_WORDS
// 64-bit words: the accept edge reads the target word, the next cycle
// modifies it and writes it back.
// Drain picks the highest word from per-word nonzero flags, then the highest
// bit inside that word.
// Reset clears the state machine and the per-word valid and nonzero flags;
// a word never written reads as zero, so all vectors start not pending.
module pending_interrupt_injector_top #(
	parameter int PENDING_WORDS = pii_pkg::PENDING_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pii_pkg::req_t req,
	output logic          done,
	output pii_pkg::rsp_t rsp
);
	import pii_pkg::*;

	localparam int IdxW = (PENDING_WORDS > 1) ? $clog2(PENDING_WORDS) : 1;

	typedef enum logic {IDLE, EXEC} state_t;

	state_t state_q;
	logic [63:0] mem [PENDING_WORDS];
	logic [PENDING_WORDS-1:0] ent_vld_q;
	logic [PENDING_WORDS-1:0] nz_q;

	req_t        req_s1;
	logic [1:0]  addr_s1;
	logic [63:0] rd_s1;
	logic        vld_s1;
	logic        any_s1;

	logic        accept;
	logic [1:0]  hi_idx;
	logic        any_nz;
	logic [1:0]  raddr;
	logic [63:0] cur;
	msb_t        msb;
	logic        wr_en;
	logic [63:0] wdata;
	rsp_t        rsp_d;

	assign accept = start && !busy;
	assign busy = (state_q == EXEC);

	always_comb begin
		hi_idx = '0;
		any_nz = 1'b0;
		for (int i = 0; i < PENDING_WORDS; i++) begin
			if (nz_q[i]) begin
				hi_idx = 2'(i);
				any_nz = 1'b1;
			end
		end
	end

	assign raddr = (req.opcode == OP_DRAIN) ? hi_idx : req.vector[7:6];

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[raddr[IdxW-1:0]];
			req_s1 <= req;
			addr_s1 <= raddr;
		end
		// write back only in the modify cycle
		if (wr_en && busy) begin
			mem[addr_s1[IdxW-1:0]] <= wdata;
		end
	end

	assign cur = vld_s1 ? rd_s1 : '0;

	pii_msb_find u_msb (
		.bits(cur),
		.msb (msb)
	);

	always_comb begin
		wr_en = 1'b0;
		wdata = cur;
		rsp_d = '0;
		case (req_s1.opcode)
			OP_INJECT_EVENT: begin
				rsp_d.injection_word = make_word(req_s1.vector, req_s1.event_type, '0, 1'b0);
				rsp_d.word_written = 1'b1;
				if (req_s1.event_type == TYPE_INTR) begin
					wdata = cur | (64'd1 << req_s1.vector[5:0]);
					wr_en = (32'(addr_s1) < PENDING_WORDS);
				end
			end
			OP_EXT_INTR: begin
				rsp_d.injection_word = make_word(req_s1.vector, TYPE_INTR, '0, 1'b0);
				rsp_d.word_written = 1'b1;
				wdata = cur | (64'd1 << req_s1.vector[5:0]);
				wr_en = (32'(addr_s1) < PENDING_WORDS);
			end
			OP_NMI: begin
				rsp_d.injection_word = make_word(NMI_VEC_NUM, TYPE_NMI, '0, 1'b0);
				rsp_d.word_written = 1'b1;
			end
			OP_EXCEPTION: begin
				rsp_d.injection_word = make_word(req_s1.vector, TYPE_EXCEPTION,
					req_s1.err_code, req_s1.code_valid);
				rsp_d.word_written = 1'b1;
			end
			OP_DRAIN: begin
				if (any_s1 && msb.found) begin
					wdata = cur & ~(64'd1 << msb.idx);
					wr_en = 1'b1;
					rsp_d.injection_word = make_word({addr_s1, msb.idx}, TYPE_INTR, '0, 1'b0);
					rsp_d.word_written = 1'b1;
					rsp_d.drain_found = 1'b1;
					rsp_d.drained_vector = {addr_s1, msb.idx};
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done <= 1'b0;
			rsp <= '0;
			ent_vld_q <= '0;
			nz_q <= '0;
			vld_s1 <= 1'b0;
			any_s1 <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						vld_s1 <= ent_vld_q[raddr[IdxW-1:0]];
						any_s1 <= any_nz;
						state_q <= EXEC;
					end
				end
				EXEC: begin
					// write back and present the result together
					if (wr_en) begin
						ent_vld_q[addr_s1[IdxW-1:0]] <= 1'b1;
						nz_q[addr_s1[IdxW-1:0]] <= |wdata;
					end
					rsp <= rsp_d;
					done <= 1'b1;
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a modify cycle");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("modify cycle longer than one cycle");

	a_found_written: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.drain_found) |-> rsp.word_written)
		else $error("drain found without a word");

	a_nz_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(nz_q & ~ent_vld_q) == '0)
		else $error("nonzero flag on a word never written");

	a_drain_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.drain_found) |-> $past(any_s1))
		else $error("drain found with no nonzero word");

endmodule

// ===== dv/pii_injection_checker.sv =====
`timescale 1ns / 1ps
// Checker for the injector: tracks the pending register, predicts each result and compares it.
module pii_injection_checker #(
	parameter int PENDING_WORDS = pii_pkg::PENDING_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  pii_pkg::req_t req,
	input  logic          done,
	input  pii_pkg::rsp_t rsp,
	output int            fail_count,
	output int            in_flight,
	output int            checked,
	output int            drains_hit,
	output int            drains_empty
);
	import pii_pkg::*;

	logic [63:0] shadow_pending [PENDING_WORDS];
	rsp_t awaited_rsp [$];
	int mismatches = 0;
	int n_checked = 0;
	int n_hit = 0;
	int n_empty = 0;

	assign fail_count = mismatches;
	assign checked = n_checked;
	assign drains_hit = n_hit;
	assign drains_empty = n_empty;

	function automatic logic [63:0] encode_injection(logic [7:0] vec, logic [2:0] kind,
		logic [31:0] code, logic with_code);
		logic [63:0] w;
		w = 64'(vec) | (64'(kind) << 8) | (64'd1 << 31);
		if (with_code)
			w = w | (64'd1 << 11) | {code, 32'h0};
		return w;
	endfunction

	// drop vectors whose word lies beyond the register
	function automatic void set_pending(logic [7:0] vec);
		int idx;
		idx = int'(vec[7:6]);
		if (idx < PENDING_WORDS)
			shadow_pending[idx][vec[5:0]] = 1'b1;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int w;
		int b;
		logic hit;
		o = '0;
		hit = 1'b0;
		case (r.opcode)
			OP_INJECT_EVENT: begin
				if (r.event_type == TYPE_INTR)
					set_pending(r.vector);
				o.injection_word = encode_injection(r.vector, r.event_type, 32'h0, 1'b0);
				o.word_written = 1'b1;
			end
			OP_EXT_INTR: begin
				set_pending(r.vector);
				o.injection_word = encode_injection(r.vector, TYPE_INTR, 32'h0, 1'b0);
				o.word_written = 1'b1;
			end
			OP_NMI: begin
				o.injection_word = encode_injection(NMI_VEC_NUM, TYPE_NMI, 32'h0, 1'b0);
				o.word_written = 1'b1;
			end
			OP_EXCEPTION: begin
				o.injection_word = encode_injection(r.vector, TYPE_EXCEPTION, r.err_code,
					r.code_valid);
				o.word_written = 1'b1;
			end
			OP_DRAIN: begin
				for (w = PENDING_WORDS - 1; w >= 0 && !hit; w--)
					for (b = 63; b >= 0 && !hit; b--)
						if (shadow_pending[w][b]) begin
							hit = 1'b1;
							shadow_pending[w][b] = 1'b0;
							o.drained_vector = 8'(w * 64 + b);
						end
				if (hit) begin
					o.injection_word = encode_injection(o.drained_vector, TYPE_INTR, 32'h0, 1'b0);
					o.word_written = 1'b1;
					o.drain_found = 1'b1;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < PENDING_WORDS; i++)
				shadow_pending[i] = '0;
			awaited_rsp.delete();
			in_flight <= 0;
		end else begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = awaited_rsp.pop_front();
					check_field("injection_word", want.injection_word, rsp.injection_word);
					check_field("word_written", 64'(want.word_written), 64'(rsp.word_written));
					check_field("drain_found", 64'(want.drain_found), 64'(rsp.drain_found));
					check_field("drained_vector", 64'(want.drained_vector),
						64'(rsp.drained_vector));
					n_checked++;
				end
			end
			if (start && !busy) begin
				want = apply_request(req);
				if (req.opcode == OP_DRAIN) begin
					if (want.drain_found)
						n_hit++;
					else
						n_empty++;
				end
				awaited_rsp.push_back(want);
			end
			in_flight <= awaited_rsp.size();
		end
	end

endmodule

// ===== dv/pending_interrupt_injector_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the injector: makes requests and gives the verdict.
module pending_interrupt_injector_top_test;
	import pii_pkg::*;

	localparam int RANDOM_REQUESTS = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	int idle_pct = 18;
	int fail_count;
	int in_flight;
	int checked;
	int drains_hit;
	int drains_empty;

	always #2 clk = ~clk;

	pending_interrupt_injector_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	pii_injection_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.fail_count(fail_count),
		.in_flight(in_flight),
		.checked(checked),
		.drains_hit(drains_hit),
		.drains_empty(drains_empty)
	);

	function automatic req_t mk_req(logic [2:0] op, logic [7:0] vec, logic [2:0] kind,
		logic [31:0] code, logic with_code);
		req_t r;
		r.opcode = op;
		r.vector = vec;
		r.event_type = kind;
		r.err_code = code;
		r.code_valid = with_code;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		pick = $urandom_range(99);
		r.vector = 8'($urandom);
		// favor the first and last vector of each word
		if ($urandom_range(7) == 0)
			r.vector[5:0] = $urandom_range(1) ? 6'h3f : 6'h00;
		r.event_type = 3'($urandom);
		r.err_code = $urandom;
		r.code_valid = 1'($urandom);
		if (pick < 15) begin
			r.opcode = OP_INJECT_EVENT;
			if ($urandom_range(1))
				r.event_type = TYPE_INTR;
		end else if (pick < 45)
			r.opcode = OP_EXT_INTR;
		else if (pick < 53)
			r.opcode = OP_NMI;
		else if (pick < 65)
			r.opcode = OP_EXCEPTION;
		else if (pick < 95)
			r.opcode = OP_DRAIN;
		else
			r.opcode = OP_DRAIN + 3'($urandom_range(1, 3));
		return r;
	endfunction

	// hold start low for random idle cycles, then present the request until taken;
	// busy is read once it has settled, ahead of the edge that may take the request
	task automatic issue(input req_t r);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		taken = 1'b0;
		while (!taken) begin
			#1;
			taken = !busy;
			@(posedge clk);
		end
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(mk_req(OP_DRAIN, 8'h00, TYPE_INTR, 32'h0, 1'b0));
		issue(mk_req(OP_DRAIN + 3'd1, 8'hff, 3'd7, 32'hffffffff, 1'b1));
		issue(mk_req(OP_DRAIN + 3'd2, 8'h55, 3'd5, 32'h12345678, 1'b0));
		issue(mk_req(OP_DRAIN + 3'd3, 8'haa, 3'd2, 32'h0, 1'b1));
		issue(mk_req(OP_EXT_INTR, 8'd0, TYPE_INTR, 32'h0, 1'b0));
		issue(mk_req(OP_EXT_INTR, 8'd255, 3'd7, 32'hffffffff, 1'b1));
		issue(mk_req(OP_INJECT_EVENT, 8'd63, TYPE_INTR, 32'h0, 1'b0));
		issue(mk_req(OP_INJECT_EVENT, 8'd64, TYPE_INTR, 32'hffffffff, 1'b1));
		issue(mk_req(OP_INJECT_EVENT, 8'd200, 3'd4, 32'h0, 1'b0));
		issue(mk_req(OP_INJECT_EVENT, 8'd128, 3'd7, 32'h0, 1'b0));
		issue(mk_req(OP_NMI, 8'd77, TYPE_INTR, 32'hffffffff, 1'b1));
		issue(mk_req(OP_EXCEPTION, 8'd255, TYPE_INTR, 32'hffffffff, 1'b1));
		issue(mk_req(OP_EXCEPTION, 8'd0, 3'd7, 32'hdeadbeef, 1'b0));
		issue(mk_req(OP_EXCEPTION, 8'd14, TYPE_INTR, 32'h0, 1'b1));
		issue(mk_req(OP_EXT_INTR, 8'd191, TYPE_INTR, 32'h0, 1'b0));
		issue(mk_req(OP_EXT_INTR, 8'd192, TYPE_INTR, 32'h0, 1'b0));
		issue(mk_req(OP_EXT_INTR, 8'd255, TYPE_INTR, 32'h0, 1'b0));
		repeat (7)
			issue(mk_req(OP_DRAIN, 8'h00, TYPE_INTR, 32'h0, 1'b0));

		// let the register settle before the random phase
		wait_quiet();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			idle_pct = (n >= 200 && n < 350) ? 0 : 18;
			issue(random_request());
		end

		wait_quiet();
		repeat (4) @(posedge clk);

		$display("covered %0d requests across all opcodes and vector boundaries", checked);
		$display("drains: %0d delivered a vector, %0d found nothing pending",
			drains_hit, drains_empty);
		if (fail_count == 0 && in_flight == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule
